/* sv/let_pkg.sv */
// ----------------------------------------------------------------------------
// Lease expiry table package
// Types, codes and constants shared by the lease expiry table modules.
// ----------------------------------------------------------------------------
package let_pkg;

    localparam int LeaseSlots = 64;
    localparam int IdxW       = $clog2(LeaseSlots);
    localparam int TimeW      = 63;
    localparam int KindW      = 3;
    localparam int OpW        = 3;
    localparam int StatW      = 2;
    localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

    typedef enum logic [OpW-1:0] {
        OP_CREATE  = 3'd0,
        OP_ARM     = 3'd1,
        OP_RENEW   = 3'd2,
        OP_RELEASE = 3'd3,
        OP_CHECK   = 3'd4
    } t_op;

    localparam logic [StatW-1:0] ST_DONE    = 2'd0;
    localparam logic [StatW-1:0] ST_EXPIRED = 2'd1;
    localparam logic [StatW-1:0] ST_NONE    = 2'd2;

    typedef struct packed {
        logic [OpW-1:0]   operation;
        logic [5:0]       lease_index;
        logic [TimeW-1:0] duration;
        logic [KindW-1:0] owner_kind;
        logic [TimeW-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [5:0]       expired_index;
        logic [KindW-1:0] expired_kind;
        logic             last;
    } t_out_item;

    // Classified command passed from front to back.
    typedef struct packed {
        logic             check;
        logic             valid_op;
        t_op              op;
        logic [IdxW-1:0]  idx;
        logic [TimeW-1:0] duration;
        logic [KindW-1:0] kind;
        logic [TimeW-1:0] now;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_RENEW,
        S_SCAN,
        S_SCANCMP,
        S_OUT
    } t_state;

    function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                                 input logic [TimeW-1:0] b);
        logic [TimeW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TimeW] ? TimeMax : s[TimeW-1:0];
    endfunction

endpackage

/* sv/let_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module let_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/let_front.sv */
// ----------------------------------------------------------------------------
// Lease table front end
// Accept input items, classify them and push commands into a two-entry queue.
// ----------------------------------------------------------------------------
module let_front import let_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_pop,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd
);
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       push;
    t_cmd       cmd;

    always_comb begin
        cmd.check    = (i_item.operation == OP_CHECK);
        cmd.valid_op = (i_item.operation <= OP_RELEASE) &&
                       ({26'd0, i_item.lease_index} < 32'(LeaseSlots));
        cmd.op       = t_op'(i_item.operation);
        cmd.idx      = IdxW'(i_item.lease_index);
        cmd.duration = i_item.duration;
        cmd.kind     = i_item.owner_kind;
        cmd.now      = i_item.now;
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_rd ^ r_cnt[0]] <= cmd;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            assert (!(i_pop && r_cnt == 2'd0))
                else $error("pop from empty queue");
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3;
    endproperty
    assert property (p_no_overflow) else $error("queue overflow");

    property p_push_counts;
        @(posedge i_clk) disable iff (!i_rst_n)
            (push && !i_pop && r_cnt == 2'd0) |=> (r_cnt == 2'd1);
    endproperty
    assert property (p_push_counts) else $error("queue count slip");

    property p_full_stalls;
        @(posedge i_clk) disable iff (!i_rst_n) (r_cnt == 2'd2) |-> o_stall;
    endproperty
    assert property (p_full_stalls) else $error("full queue not stalling");
endmodule

/* sv/let_back.sv */
// ----------------------------------------------------------------------------
// Lease table back end
// Execute commands against the lease stores and produce result items.
// ----------------------------------------------------------------------------
module let_back import let_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    t_state r_state, n_state;
    logic [LeaseSlots-1:0] r_alloc, n_alloc;
    logic [LeaseSlots-1:0] r_armed, n_armed;
    logic [IdxW-1:0] r_ptr, n_ptr;
    logic [IdxW-1:0] r_lidx, n_lidx;
    logic            r_pend, n_pend;
    logic [IdxW-1:0] r_pidx, n_pidx;
    logic [KindW-1:0] r_pkind, n_pkind;
    logic            r_fin, n_fin;
    logic            r_oval, n_oval;
    t_out_item       r_out, n_out;
    t_out_item       r_res, n_res;
    t_cmd            r_cmd, n_cmd;
    logic [TimeW-1:0] r_ren, n_ren;

    logic             dur_we, end_we, own_we;
    logic [IdxW-1:0]  waddr, raddr;
    logic [TimeW-1:0] dur_wd, end_wd;
    logic [TimeW-1:0] dur_rd, end_rd;
    logic [KindW-1:0] own_rd;
    logic             out_free;
    logic             hit;

    let_ram #(.Width(TimeW), .Depth(LeaseSlots)) u_dur (
        .i_clk(i_clk), .i_we(dur_we), .i_waddr(waddr), .i_wdata(dur_wd),
        .i_raddr(raddr), .o_rdata(dur_rd));
    let_ram #(.Width(TimeW), .Depth(LeaseSlots)) u_end (
        .i_clk(i_clk), .i_we(end_we), .i_waddr(waddr), .i_wdata(end_wd),
        .i_raddr(raddr), .o_rdata(end_rd));
    let_ram #(.Width(KindW), .Depth(LeaseSlots)) u_own (
        .i_clk(i_clk), .i_we(own_we), .i_waddr(waddr), .i_wdata(r_cmd.kind),
        .i_raddr(raddr), .o_rdata(own_rd));

    assign out_free = !r_oval || !i_stall;
    assign o_valid  = r_oval;
    assign o_item   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_alloc <= '0;
            r_armed <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_alloc <= n_alloc;
            r_armed <= n_armed;
            r_oval  <= n_oval;
        end
        r_ptr   <= n_ptr;
        r_lidx  <= n_lidx;
        r_pend  <= n_pend;
        r_pidx  <= n_pidx;
        r_pkind <= n_pkind;
        r_fin   <= n_fin;
        r_out   <= n_out;
        r_res   <= n_res;
        r_cmd   <= n_cmd;
        r_ren   <= n_ren;
    end

    always_comb begin
        n_state = r_state;
        n_alloc = r_alloc;
        n_armed = r_armed;
        n_ptr   = r_ptr;
        n_lidx  = r_lidx;
        n_pend  = r_pend;
        n_pidx  = r_pidx;
        n_pkind = r_pkind;
        n_fin   = r_fin;
        n_oval  = r_oval && i_stall;
        n_out   = r_out;
        n_res   = r_res;
        n_cmd   = r_cmd;
        n_ren   = r_ren;
        hit     = 1'b0;
        o_pop   = 1'b0;
        dur_we  = 1'b0;
        end_we  = 1'b0;
        own_we  = 1'b0;
        waddr   = r_cmd.idx;
        dur_wd  = r_cmd.duration;
        end_wd  = sat_add(r_cmd.now, r_cmd.duration);
        raddr   = r_cmd.idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_ptr   = '0;
                    n_pend  = 1'b0;
                    n_state = i_cmd.check ? S_SCAN : S_RD;
                end
            end
            S_RD: begin
                // Perform the single-slot operation; renew needs a read first.
                if (r_cmd.valid_op) begin
                    unique case (r_cmd.op)
                        OP_CREATE: begin
                            dur_we = 1'b1;
                            end_we = 1'b1;
                            own_we = 1'b1;
                            n_alloc[r_cmd.idx] = 1'b1;
                            n_armed[r_cmd.idx] = 1'b0;
                        end
                        OP_ARM: begin
                            if (r_alloc[r_cmd.idx]) begin
                                n_armed[r_cmd.idx] = 1'b1;
                            end
                        end
                        OP_RELEASE: begin
                            n_alloc[r_cmd.idx] = 1'b0;
                            n_armed[r_cmd.idx] = 1'b0;
                        end
                        default: ;
                    endcase
                end
                if (r_cmd.valid_op && r_cmd.op == OP_RENEW && r_alloc[r_cmd.idx]) begin
                    n_state = S_RENEW;
                end else begin
                    n_res   = '{ST_DONE, 6'd0, '0, 1'b1};
                    n_state = S_OUT;
                end
            end
            S_RENEW: begin
                end_wd = sat_add(r_cmd.now, dur_rd);
                end_we = (end_wd > end_rd);
                n_res   = '{ST_DONE, 6'd0, '0, 1'b1};
                n_state = S_OUT;
            end
            S_SCAN: begin
                // Issue read of slot r_ptr; compare next cycle.
                raddr   = r_ptr;
                n_lidx  = r_ptr;
                n_state = S_SCANCMP;
            end
            S_SCANCMP: begin
                hit   = r_armed[r_lidx] && r_alloc[r_lidx] && (end_rd <= r_cmd.now);
                n_fin = ({1'b0, r_lidx} == (IdxW+1)'(LeaseSlots - 1));
                if (hit) begin
                    n_armed[r_lidx] = 1'b0;
                    n_alloc[r_lidx] = 1'b0;
                    n_pidx  = r_lidx;
                    n_pkind = own_rd;
                    n_pend  = 1'b1;
                    if (r_pend) begin
                        // A later hit exists, so the held one is not the last.
                        n_res   = '{ST_EXPIRED, 6'(r_pidx), r_pkind, 1'b0};
                        n_state = S_OUT;
                    end else if (n_fin) begin
                        n_res   = '{ST_EXPIRED, 6'(r_lidx), own_rd, 1'b1};
                        n_pend  = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_ptr   = r_lidx + 1'b1;
                        n_state = S_SCAN;
                    end
                end else if (n_fin) begin
                    if (r_pend) begin
                        n_res = '{ST_EXPIRED, 6'(r_pidx), r_pkind, 1'b1};
                    end else begin
                        n_res = '{ST_NONE, 6'd0, '0, 1'b1};
                    end
                    n_pend  = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_ptr   = r_lidx + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_OUT: begin
                // Hold the result until the output register frees.
                if (out_free) begin
                    n_out   = r_res;
                    n_oval  = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd.check && !r_res.last) begin
                        if (r_fin) begin
                            n_res   = '{ST_EXPIRED, 6'(r_pidx), r_pkind, 1'b1};
                            n_pend  = 1'b0;
                            n_state = S_OUT;
                        end else begin
                            n_ptr   = r_lidx + 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Each expiry is held back until the next hit or the end of the scan,
    // which decides whether it carries last.

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_oval && i_stall) |=> (r_oval && $stable(r_out));
    endproperty
    assert property (p_out_hold) else $error("result dropped under stall");

    property p_pop_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_pop |-> (r_state == S_IDLE);
    endproperty
    assert property (p_pop_idle) else $error("pop outside idle");

    property p_done_last;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_oval && r_out.status != ST_EXPIRED) |-> r_out.last;
    endproperty
    assert property (p_done_last) else $error("single result without last");
endmodule

/* sv/lease_expiry_table_core.sv */
// Single-slot operations pass from idle through the read state (and the renew state
// for a renew) to the output state. A check visits each slot in a scan state and a
// compare state, plus an output state per expiry report, paced by the shared store
// read address. One item at a time in the back end; the front queue takes two more.
// Reset: synchronous active low; clears allocated and armed bits at once, no sweep.
// ----------------------------------------------------------------------------
// Lease expiry table core
// Front end classifies transactions into a short queue; back end applies
// them to the lease stores and streams expiry reports.
// ----------------------------------------------------------------------------
module lease_expiry_table_core import let_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    logic cmd_valid;
    logic pop;
    t_cmd cmd;

    // Accept and classify transactions; hold up to two pending commands.
    let_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .i_pop(pop), .o_cmd_valid(cmd_valid), .o_cmd(cmd));

    // Execute commands one by one; scan the table on a check.
    let_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_pop(pop),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item));
endmodule
